>>> rtl/atrp_pkg.sv
package atrp_pkg;

   // corrected axis, square, sum of squares
   localparam int SAMPLE_W = 16;
   localparam int OFFSET_W = 18;
   localparam int AXIS_W   = 19;
   localparam int SQ_W     = 35;
   localparam int SUM_W    = 36;

   // square root of (sum << RAD_FRAC), one root bit per cell
   localparam int RAD_FRAC   = 16;
   localparam int ROOT_W     = 26;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int REM_W      = ROOT_W + 3;

   // cordic datapath
   localparam int Y0_FRAC = 8;
   localparam int Y0_W    = AXIS_W + Y0_FRAC;
   localparam int XY_W    = 30;
   localparam int Z_W     = 32;
   localparam int Z_FRAC  = 16;
   localparam int TAB_LEN = 24;

   // result
   localparam int ANGLE_W = 15;
   localparam int ROUND_W = Z_W - Z_FRAC;
   localparam logic signed [ROUND_W-1:0] FULL_RIGHT_WIDE = 16'sd9000;
   localparam logic signed [ANGLE_W-1:0] FULL_RIGHT      = 15'sd9000;

   // register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_SECOND = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_THIRD  = 2'd2;

   typedef struct packed {
      logic valid;
      logic zero_den;
      logic zero_num;
      logic neg_num;
   } atrp_ctl_type;

   // atan(2^-i) in 1/65536 centidegree, rounded to nearest
   function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
      logic signed [Z_W-1:0] val;
      unique case (idx)
         5'd0:    val = 32'sd294912000;
         5'd1:    val = 32'sd174096719;
         5'd2:    val = 32'sd91987925;
         5'd3:    val = 32'sd46694507;
         5'd4:    val = 32'sd23437865;
         5'd5:    val = 32'sd11730358;
         5'd6:    val = 32'sd5866610;
         5'd7:    val = 32'sd2933484;
         5'd8:    val = 32'sd1466764;
         5'd9:    val = 32'sd733385;
         5'd10:   val = 32'sd366693;
         5'd11:   val = 32'sd183346;
         5'd12:   val = 32'sd91673;
         5'd13:   val = 32'sd45837;
         5'd14:   val = 32'sd22918;
         5'd15:   val = 32'sd11459;
         5'd16:   val = 32'sd5730;
         5'd17:   val = 32'sd2865;
         5'd18:   val = 32'sd1432;
         5'd19:   val = 32'sd716;
         5'd20:   val = 32'sd358;
         5'd21:   val = 32'sd179;
         5'd22:   val = 32'sd90;
         5'd23:   val = 32'sd45;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> rtl/atrp_sqrt_cell.sv
module atrp_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  atrp_pkg::atrp_ctl_type               ctl_i,
   input  logic [atrp_pkg::SUM_W-1:0]           rad_i,
   input  logic [atrp_pkg::REM_W-1:0]           rem_i,
   input  logic [atrp_pkg::ROOT_W-1:0]          root_i,
   input  logic signed [atrp_pkg::Y0_W-1:0]     y_i,
   output atrp_pkg::atrp_ctl_type               ctl_o,
   output logic [atrp_pkg::SUM_W-1:0]           rad_o,
   output logic [atrp_pkg::REM_W-1:0]           rem_o,
   output logic [atrp_pkg::ROOT_W-1:0]          root_o,
   output logic signed [atrp_pkg::Y0_W-1:0]     y_o
);

   localparam int WIDE_W = atrp_pkg::SUM_W + atrp_pkg::RAD_FRAC;

   logic [WIDE_W-1:0]               wide;
   logic [1:0]                      pair;
   logic [atrp_pkg::REM_W-1:0]      rem_sh;
   logic [atrp_pkg::REM_W-1:0]      trial;
   logic                            take;

   atrp_pkg::atrp_ctl_type          ctl_ff;
   logic [atrp_pkg::SUM_W-1:0]      rad_ff;
   logic [atrp_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [atrp_pkg::ROOT_W-1:0]     root_ff, root_in;
   logic signed [atrp_pkg::Y0_W-1:0] y_ff;

   // bring down the next pair of radicand bits and try a one
   always_comb begin
      wide    = {rad_i, {atrp_pkg::RAD_FRAC{1'b0}}};
      pair    = wide[2*STEP +: 2];
      rem_sh  = {rem_i[atrp_pkg::REM_W-3:0], pair};
      trial   = atrp_pkg::REM_W'({root_i, 2'b01});
      take    = (rem_sh >= trial);
      rem_in  = take ? (rem_sh - trial) : rem_sh;
      root_in = {root_i[atrp_pkg::ROOT_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_i;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      y_ff    <= y_i;
   end

   assign ctl_o  = ctl_ff;
   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign y_o    = y_ff;

endmodule

>>> rtl/atrp_cordic_cell.sv
module atrp_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  atrp_pkg::atrp_ctl_type             ctl_i,
   input  logic signed [atrp_pkg::XY_W-1:0]   x_i,
   input  logic signed [atrp_pkg::XY_W-1:0]   y_i,
   input  logic signed [atrp_pkg::Z_W-1:0]    z_i,
   output atrp_pkg::atrp_ctl_type             ctl_o,
   output logic signed [atrp_pkg::XY_W-1:0]   x_o,
   output logic signed [atrp_pkg::XY_W-1:0]   y_o,
   output logic signed [atrp_pkg::Z_W-1:0]    z_o
);

   localparam logic signed [atrp_pkg::Z_W-1:0] ANGLE = atrp_pkg::atan_entry(5'(STEP));

   logic signed [atrp_pkg::XY_W-1:0] xs, ys;
   atrp_pkg::atrp_ctl_type           ctl_ff;
   logic signed [atrp_pkg::XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [atrp_pkg::Z_W-1:0]  z_ff, z_in;

   // rotate towards y = 0, arithmetic shifts round towards minus infinity
   always_comb begin
      xs = x_i >>> STEP;
      ys = y_i >>> STEP;
      if (!y_i[atrp_pkg::XY_W-1]) begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + ANGLE;
      end else begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign ctl_o = ctl_ff;
   assign x_o   = x_ff;
   assign y_o   = y_ff;
   assign z_o   = z_ff;

endmodule

>>> rtl/atrp_angle_lane.sv
module atrp_angle_lane #(
   parameter int ITERATIONS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  valid_i,
   input  logic signed [atrp_pkg::AXIS_W-1:0]    num_i,
   input  logic [atrp_pkg::SQ_W-1:0]             sq_a_i,
   input  logic [atrp_pkg::SQ_W-1:0]             sq_b_i,
   output logic                                  valid_o,
   output logic signed [atrp_pkg::ANGLE_W-1:0]   angle_o,
   output logic                                  degen_o
);

   localparam int STAGES = (ITERATIONS < atrp_pkg::TAB_LEN) ? ITERATIONS : atrp_pkg::TAB_LEN;
   localparam int NSQ    = atrp_pkg::SQRT_STEPS;

   // denominator sum and special-case flags
   atrp_pkg::atrp_ctl_type             ctl_ff, ctl_in;
   logic [atrp_pkg::SUM_W-1:0]         sum_ff, sum_in;
   logic signed [atrp_pkg::Y0_W-1:0]   y0_ff, y0_in;

   always_comb begin
      sum_in          = {1'b0, sq_a_i} + {1'b0, sq_b_i};
      y0_in           = {num_i, {atrp_pkg::Y0_FRAC{1'b0}}};
      ctl_in.valid    = valid_i;
      ctl_in.zero_den = (sum_in == '0);
      ctl_in.zero_num = (num_i == '0);
      ctl_in.neg_num  = num_i[atrp_pkg::AXIS_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      y0_ff  <= y0_in;
   end

   // square root chain
   atrp_pkg::atrp_ctl_type            sq_ctl  [NSQ+1];
   logic [atrp_pkg::SUM_W-1:0]        sq_rad  [NSQ+1];
   logic [atrp_pkg::REM_W-1:0]        sq_rem  [NSQ+1];
   logic [atrp_pkg::ROOT_W-1:0]       sq_root [NSQ+1];
   logic signed [atrp_pkg::Y0_W-1:0]  sq_y    [NSQ+1];

   assign sq_ctl[0]  = ctl_ff;
   assign sq_rad[0]  = sum_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_y[0]    = y0_ff;

   for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
      atrp_sqrt_cell #(
         .STEP (NSQ - 1 - j)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl_i  (sq_ctl[j]),
         .rad_i  (sq_rad[j]),
         .rem_i  (sq_rem[j]),
         .root_i (sq_root[j]),
         .y_i    (sq_y[j]),
         .ctl_o  (sq_ctl[j+1]),
         .rad_o  (sq_rad[j+1]),
         .rem_o  (sq_rem[j+1]),
         .root_o (sq_root[j+1]),
         .y_o    (sq_y[j+1])
      );
   end

   // cordic chain
   atrp_pkg::atrp_ctl_type            cd_ctl [STAGES+1];
   logic signed [atrp_pkg::XY_W-1:0]  cd_x   [STAGES+1];
   logic signed [atrp_pkg::XY_W-1:0]  cd_y   [STAGES+1];
   logic signed [atrp_pkg::Z_W-1:0]   cd_z   [STAGES+1];

   assign cd_ctl[0] = sq_ctl[NSQ];
   assign cd_x[0]   = atrp_pkg::XY_W'(sq_root[NSQ]);
   assign cd_y[0]   = atrp_pkg::XY_W'(sq_y[NSQ]);
   assign cd_z[0]   = '0;

   for (genvar i = 0; i < STAGES; i++) begin : g_cordic
      atrp_cordic_cell #(
         .STEP (i)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .ctl_i (cd_ctl[i]),
         .x_i   (cd_x[i]),
         .y_i   (cd_y[i]),
         .z_i   (cd_z[i]),
         .ctl_o (cd_ctl[i+1]),
         .x_o   (cd_x[i+1]),
         .y_o   (cd_y[i+1]),
         .z_o   (cd_z[i+1])
      );
   end

   // round, saturate and apply the special cases
   atrp_pkg::atrp_ctl_type                 fin;
   logic signed [atrp_pkg::Z_W-1:0]        z_rnd;
   logic signed [atrp_pkg::ROUND_W-1:0]    r_wide;
   logic signed [atrp_pkg::ANGLE_W-1:0]    r_sat;
   logic                                   valid_ff, valid_in;
   logic                                   degen_ff, degen_in;
   logic signed [atrp_pkg::ANGLE_W-1:0]    angle_ff, angle_in;

   always_comb begin
      fin    = cd_ctl[STAGES];
      z_rnd  = cd_z[STAGES] + (atrp_pkg::Z_W'(1) <<< (atrp_pkg::Z_FRAC - 1));
      r_wide = z_rnd[atrp_pkg::Z_W-1:atrp_pkg::Z_FRAC];
      priority if (r_wide > atrp_pkg::FULL_RIGHT_WIDE) begin
         r_sat = atrp_pkg::FULL_RIGHT;
      end else if (r_wide < -atrp_pkg::FULL_RIGHT_WIDE) begin
         r_sat = -atrp_pkg::FULL_RIGHT;
      end else begin
         r_sat = r_wide[atrp_pkg::ANGLE_W-1:0];
      end

      priority if (fin.zero_den && fin.neg_num) begin
         angle_in = -atrp_pkg::FULL_RIGHT;
      end else if (fin.zero_den && !fin.zero_num) begin
         angle_in = atrp_pkg::FULL_RIGHT;
      end else if (fin.zero_num) begin
         angle_in = '0;
      end else begin
         angle_in = r_sat;
      end

      valid_in = fin.valid;
      degen_in = fin.valid && fin.zero_den && fin.zero_num;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         degen_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         degen_ff <= degen_in;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
   end

   assign valid_o = valid_ff;
   assign angle_o = angle_ff;
   assign degen_o = degen_ff;

endmodule

>>> rtl/accel_tilt_roll_pitch.sv
// accelerometer tilt: roll = atan(a0 / sqrt(a1^2 + a2^2)) and pitch = atan(-a2 / sqrt(a1^2 +
// a0^2)) in hundredths of a degree, where each axis is the raw sample plus its csr offset.
// fully pipelined: a request is taken in every clock cycle (busy is never raised) and its
// result comes out in request order, as a one-cycle pulse on rsp_valid. the pipeline is the
// chain of 26 square-root cells (one root bit each) and the cordic cells, one per iteration
// up to the atan table length, plus offset, square, sum and output stages. there is no
// back-pressure on the response side: the receiver must take every pulse. offsets should
// only be written while no request is in flight. a zero denominator gives +/-9000, and
// zero over zero gives 0 with rsp_degenerate set.
module accel_tilt_roll_pitch #(
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // request
   input  logic                                      start,
   output logic                                      busy,
   input  logic signed [atrp_pkg::SAMPLE_W-1:0]      req_sample_first,
   input  logic signed [atrp_pkg::SAMPLE_W-1:0]      req_sample_second,
   input  logic signed [atrp_pkg::SAMPLE_W-1:0]      req_sample_third,
   // response
   output logic                                      rsp_valid,
   output logic signed [atrp_pkg::ANGLE_W-1:0]       rsp_roll_centideg,
   output logic signed [atrp_pkg::ANGLE_W-1:0]       rsp_pitch_centideg,
   output logic                                      rsp_degenerate,
   // csr write port
   input  logic                                      csr_we,
   input  logic [atrp_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [atrp_pkg::OFFSET_W-1:0]             csr_wdata
);

   localparam int STAGES  = (ANGLE_ITERATIONS < atrp_pkg::TAB_LEN) ?
                            ANGLE_ITERATIONS : atrp_pkg::TAB_LEN;
   localparam int LATENCY = atrp_pkg::SQRT_STEPS + STAGES + 4;

   // the pipeline never stalls
   assign busy = 1'b0;

   // calibration offsets
   logic signed [atrp_pkg::OFFSET_W-1:0] off_first_ff, off_second_ff, off_third_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_first_ff  <= '0;
         off_second_ff <= '0;
         off_third_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            atrp_pkg::CSR_OFFSET_FIRST:  off_first_ff  <= csr_wdata;
            atrp_pkg::CSR_OFFSET_SECOND: off_second_ff <= csr_wdata;
            atrp_pkg::CSR_OFFSET_THIRD:  off_third_ff  <= csr_wdata;
            default: ;   // unused index, write dropped
         endcase
      end
   end

   // stage 1: corrected axes, exact in 19 bits
   logic                                 v1_ff;
   logic signed [atrp_pkg::AXIS_W-1:0]   a0_ff, a0_in, a1_ff, a1_in, a2_ff, a2_in;

   always_comb begin
      a0_in = atrp_pkg::AXIS_W'(req_sample_first)  + atrp_pkg::AXIS_W'(off_first_ff);
      a1_in = atrp_pkg::AXIS_W'(req_sample_second) + atrp_pkg::AXIS_W'(off_second_ff);
      a2_in = atrp_pkg::AXIS_W'(req_sample_third)  + atrp_pkg::AXIS_W'(off_third_ff);
   end

   // stage 2: squares, and the numerators handed on with them
   localparam int PROD_W = 2 * atrp_pkg::AXIS_W;

   logic                                 v2_ff;
   logic signed [PROD_W-1:0]             p0, p1, p2;
   logic [atrp_pkg::SQ_W-1:0]            q0_ff, q1_ff, q2_ff;
   logic signed [atrp_pkg::AXIS_W-1:0]   n_roll_ff, n_pitch_ff;

   always_comb begin
      p0 = PROD_W'(a0_ff) * PROD_W'(a0_ff);
      p1 = PROD_W'(a1_ff) * PROD_W'(a1_ff);
      p2 = PROD_W'(a2_ff) * PROD_W'(a2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      a0_ff      <= a0_in;
      a1_ff      <= a1_in;
      a2_ff      <= a2_in;
      q0_ff      <= p0[atrp_pkg::SQ_W-1:0];
      q1_ff      <= p1[atrp_pkg::SQ_W-1:0];
      q2_ff      <= p2[atrp_pkg::SQ_W-1:0];
      n_roll_ff  <= a0_ff;
      n_pitch_ff <= -a2_ff;   // -163840 negates into range
   end

   // one lane per angle
   logic                                  roll_valid, pitch_valid;
   logic                                  roll_degen, pitch_degen;
   logic signed [atrp_pkg::ANGLE_W-1:0]   roll_angle, pitch_angle;

   atrp_angle_lane #(
      .ITERATIONS (STAGES)
   ) u_roll (
      .clock   (clock),
      .reset   (reset),
      .valid_i (v2_ff),
      .num_i   (n_roll_ff),
      .sq_a_i  (q1_ff),
      .sq_b_i  (q2_ff),
      .valid_o (roll_valid),
      .angle_o (roll_angle),
      .degen_o (roll_degen)
   );

   atrp_angle_lane #(
      .ITERATIONS (STAGES)
   ) u_pitch (
      .clock   (clock),
      .reset   (reset),
      .valid_i (v2_ff),
      .num_i   (n_pitch_ff),
      .sq_a_i  (q1_ff),
      .sq_b_i  (q0_ff),
      .valid_o (pitch_valid),
      .angle_o (pitch_angle),
      .degen_o (pitch_degen)
   );

   // both lanes run in lockstep
   assign rsp_valid          = roll_valid && pitch_valid;
   assign rsp_roll_centideg  = roll_angle;
   assign rsp_pitch_centideg = pitch_angle;
   assign rsp_degenerate     = roll_degen || pitch_degen;

   // every accepted request answers after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("request without response at fixed latency");

   // the lanes must never drift apart
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      roll_valid == pitch_valid)
      else $error("roll and pitch lanes out of step");

   // zero over zero forces both angles to zero
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_degenerate |-> (rsp_valid && rsp_roll_centideg == '0 && rsp_pitch_centideg == '0))
      else $error("degenerate response with non-zero angle");

   // saturation keeps angles within a quarter turn
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_centideg <= atrp_pkg::FULL_RIGHT &&
                     rsp_roll_centideg >= -atrp_pkg::FULL_RIGHT &&
                     rsp_pitch_centideg <= atrp_pkg::FULL_RIGHT &&
                     rsp_pitch_centideg >= -atrp_pkg::FULL_RIGHT))
      else $error("angle outside +/-9000");

endmodule
